FILE: rtl/all_pairs_shortest_paths_core_macros.svh
// ----------------------------------------------------------------------------
// all_pairs_shortest_paths_core_macros
// assertion macros used by the shortest path core file
// ----------------------------------------------------------------------------
`ifndef ALL_PAIRS_SHORTEST_PATHS_CORE_MACROS_SVH
`define ALL_PAIRS_SHORTEST_PATHS_CORE_MACROS_SVH

// same cycle implication
`define APSP_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next cycle implication
`define APSP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/apsp_pkg.sv
// ----------------------------------------------------------------------------
// apsp_pkg
// field widths, codes and sequencer states of the shortest path core
// ----------------------------------------------------------------------------
package apsp_pkg;

  localparam int OP_BITS         = 2;
  localparam int NODE_BITS       = 4;
  localparam int WEIGHT_BITS     = 16;
  localparam int DIST_OUT_BITS   = 21;
  localparam int NODE_COUNT_BITS = 5;
  localparam int UNREACH_BITS    = 20;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int CFG_DATA_BITS   = 20;

  localparam logic [NODE_COUNT_BITS-1:0] NODE_COUNT_RESET = 5'd16;
  localparam logic [UNREACH_BITS-1:0]    UNREACH_RESET    = 20'd100000;

  typedef enum logic [OP_BITS-1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_RUN   = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_NODE_COUNT = 2'd0,
    CFG_UNREACH    = 2'd1
  } cfg_index_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CLEAR = 6'b000010,
    ST_READ  = 6'b000100,
    ST_RD1   = 6'b001000,
    ST_RD2   = 6'b010000,
    ST_WR    = 6'b100000
  } state_t;

endpackage

FILE: rtl/apsp_ram.sv
// ----------------------------------------------------------------------------
// apsp_ram
// generic memory, one write port and two registered read ports
// ----------------------------------------------------------------------------
module apsp_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: rtl/apsp_alu.sv
// ----------------------------------------------------------------------------
// apsp_alu
// shared saturating adder and relaxation compare
// ----------------------------------------------------------------------------
module apsp_alu #(
  parameter int DIST_BITS = 21,
  parameter int CW        = 23
) (
  input  logic signed [CW-1:0]        opa,
  input  logic signed [CW-1:0]        opb,
  input  logic signed [DIST_BITS-1:0] cur,
  input  logic signed [DIST_BITS-1:0] via,
  output logic signed [DIST_BITS-1:0] sum,
  output logic                        replace
);

  localparam logic signed [CW-1:0] DMAX =
    {{(CW-DIST_BITS+1){1'b0}}, {(DIST_BITS-1){1'b1}}};
  localparam logic signed [CW-1:0] DMIN = ~DMAX;

  logic signed [CW-1:0] full;

  assign full = opa + opb;

  always_comb begin
    if (full > DMAX) begin
      sum = DMAX[DIST_BITS-1:0];
    end else if (full < DMIN) begin
      sum = DMIN[DIST_BITS-1:0];
    end else begin
      sum = full[DIST_BITS-1:0];
    end
  end

  assign replace = cur > via;

endmodule

FILE: rtl/all_pairs_shortest_paths_core.sv
// ----------------------------------------------------------------------------
// all_pairs_shortest_paths_core
// Distance matrix of MAX_NODES by MAX_NODES signed entries in one memory
// with a single shared saturating adder. After reset, and for every clear
// item, the block sweeps the whole memory one entry a cycle and is not
// ready meanwhile. A load item is written as it is accepted; a read item
// passes the read state before its result sits in the output register. A
// run item for n active nodes steps k, i and j over those nodes: each
// relaxation step reads three entries through the two read ports of the
// memory, adds, then compares and writes back. No item is taken while a
// read result waits in the output register, and the configuration port is
// ready only while the block is idle.
// ----------------------------------------------------------------------------
`include "all_pairs_shortest_paths_core_macros.svh"

module all_pairs_shortest_paths_core #(
  parameter int MAX_NODES = 16,
  parameter int DIST_BITS = 21
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic [apsp_pkg::OP_BITS-1:0]              operation,
  input  logic [apsp_pkg::NODE_BITS-1:0]            src_node,
  input  logic [apsp_pkg::NODE_BITS-1:0]            dst_node,
  input  logic signed [apsp_pkg::WEIGHT_BITS-1:0]   edge_weight,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic signed [apsp_pkg::DIST_OUT_BITS-1:0] distance,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [apsp_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
  input  logic [apsp_pkg::CFG_DATA_BITS-1:0]        cfg_data
);

  localparam int IDX_BITS  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int ADDR_BITS = 2 * IDX_BITS;
  localparam int DEPTH     = 1 << ADDR_BITS;
  localparam int CW        =
    ((DIST_BITS > apsp_pkg::UNREACH_BITS) ? DIST_BITS : apsp_pkg::UNREACH_BITS) + 2;

  apsp_pkg::state_t state;

  logic [apsp_pkg::NODE_COUNT_BITS-1:0] node_count;
  logic [apsp_pkg::UNREACH_BITS-1:0]    unreachable_value;

  logic [ADDR_BITS-1:0] sweep_addr;
  logic                 init_sweep;
  logic [IDX_BITS-1:0]  k_idx;
  logic [IDX_BITS-1:0]  i_idx;
  logic [IDX_BITS-1:0]  j_idx;
  logic [IDX_BITS-1:0]  n_last;
  logic                 rd_ok;
  logic signed [DIST_BITS-1:0] via;

  logic                 in_accept;
  logic                 src_ok;
  logic                 dst_ok;
  logic [IDX_BITS-1:0]  src_idx;
  logic [IDX_BITS-1:0]  dst_idx;
  logic [7:0]           n_clip;
  logic                 last_j;
  logic                 last_i;
  logic                 last_k;

  logic                 ram_we;
  logic [ADDR_BITS-1:0] ram_waddr;
  logic [DIST_BITS-1:0] ram_wdata;
  logic [ADDR_BITS-1:0] ram_raddr_a;
  logic [ADDR_BITS-1:0] ram_raddr_b;
  logic [DIST_BITS-1:0] ram_qa;
  logic [DIST_BITS-1:0] ram_qb;

  logic signed [CW-1:0]        alu_a;
  logic signed [CW-1:0]        alu_b;
  logic signed [DIST_BITS-1:0] alu_sum;
  logic                        alu_replace;

  assign in_accept = in_valid && in_ready;
  assign in_ready  = (state == apsp_pkg::ST_IDLE) && (!out_valid || out_ready);
  assign cfg_ready = (state == apsp_pkg::ST_IDLE);

  assign src_ok  = 8'(src_node) < 8'(MAX_NODES);
  assign dst_ok  = 8'(dst_node) < 8'(MAX_NODES);
  assign src_idx = IDX_BITS'(src_node);
  assign dst_idx = IDX_BITS'(dst_node);
  assign n_clip  = (8'(node_count) > 8'(MAX_NODES)) ? 8'(MAX_NODES) : 8'(node_count);

  assign last_j = j_idx == n_last;
  assign last_i = i_idx == n_last;
  assign last_k = k_idx == n_last;

  // memory port and shared adder steering
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = {src_idx, dst_idx};
    ram_wdata   = alu_sum;
    ram_raddr_a = {src_idx, dst_idx};
    ram_raddr_b = {k_idx, j_idx};
    alu_a       = CW'(edge_weight);
    alu_b       = '0;
    case (state)
      apsp_pkg::ST_IDLE: begin
        ram_we = in_accept && (operation == apsp_pkg::OP_LOAD) && src_ok && dst_ok;
      end
      apsp_pkg::ST_CLEAR: begin
        alu_a     = init_sweep ? CW'(apsp_pkg::UNREACH_RESET) : CW'(unreachable_value);
        ram_we    = 1'b1;
        ram_waddr = sweep_addr;
        if (sweep_addr[ADDR_BITS-1:IDX_BITS] == sweep_addr[IDX_BITS-1:0]) begin
          ram_wdata = '0;
        end
      end
      apsp_pkg::ST_RD1: begin
        ram_raddr_a = {i_idx, k_idx};
      end
      apsp_pkg::ST_RD2: begin
        ram_raddr_a = {i_idx, j_idx};
        alu_a       = CW'(signed'(ram_qa));
        alu_b       = CW'(signed'(ram_qb));
      end
      apsp_pkg::ST_WR: begin
        ram_we    = alu_replace;
        ram_waddr = {i_idx, j_idx};
        ram_wdata = via;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= apsp_pkg::ST_CLEAR;
      sweep_addr        <= '0;
      init_sweep        <= 1'b1;
      out_valid         <= 1'b0;
      node_count        <= apsp_pkg::NODE_COUNT_RESET;
      unreachable_value <= apsp_pkg::UNREACH_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          apsp_pkg::CFG_NODE_COUNT: node_count <= cfg_data[apsp_pkg::NODE_COUNT_BITS-1:0];
          apsp_pkg::CFG_UNREACH:    unreachable_value <= cfg_data;
          default: begin
          end
        endcase
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        apsp_pkg::ST_IDLE: begin
          if (in_accept) begin
            case (operation)
              apsp_pkg::OP_CLEAR: begin
                state      <= apsp_pkg::ST_CLEAR;
                sweep_addr <= '0;
                init_sweep <= 1'b0;
              end
              apsp_pkg::OP_RUN: begin
                if (n_clip != 8'd0) begin
                  state  <= apsp_pkg::ST_RD1;
                  k_idx  <= '0;
                  i_idx  <= '0;
                  j_idx  <= '0;
                  n_last <= IDX_BITS'(n_clip - 8'd1);
                end
              end
              apsp_pkg::OP_READ: begin
                state <= apsp_pkg::ST_READ;
                rd_ok <= src_ok && dst_ok;
              end
              default: begin
              end
            endcase
          end
        end
        apsp_pkg::ST_CLEAR: begin
          sweep_addr <= sweep_addr + ADDR_BITS'(1);
          if (&sweep_addr) begin
            state <= apsp_pkg::ST_IDLE;
          end
        end
        apsp_pkg::ST_READ: begin
          out_valid <= 1'b1;
          distance  <= rd_ok ? apsp_pkg::DIST_OUT_BITS'(signed'(ram_qa)) : '0;
          state     <= apsp_pkg::ST_IDLE;
        end
        apsp_pkg::ST_RD1: begin
          state <= apsp_pkg::ST_RD2;
        end
        apsp_pkg::ST_RD2: begin
          via   <= alu_sum;
          state <= apsp_pkg::ST_WR;
        end
        apsp_pkg::ST_WR: begin
          state <= apsp_pkg::ST_RD1;
          if (!last_j) begin
            j_idx <= j_idx + IDX_BITS'(1);
          end else begin
            j_idx <= '0;
            if (!last_i) begin
              i_idx <= i_idx + IDX_BITS'(1);
            end else begin
              i_idx <= '0;
              if (!last_k) begin
                k_idx <= k_idx + IDX_BITS'(1);
              end else begin
                state <= apsp_pkg::ST_IDLE;
              end
            end
          end
        end
        default: begin
          state <= apsp_pkg::ST_IDLE;
        end
      endcase
    end
  end

  apsp_ram #(
    .WIDTH (DIST_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .rdata_a (ram_qa),
    .raddr_b (ram_raddr_b),
    .rdata_b (ram_qb)
  );

  apsp_alu #(
    .DIST_BITS (DIST_BITS),
    .CW        (CW)
  ) u_alu (
    .opa     (alu_a),
    .opb     (alu_b),
    .cur     (signed'(ram_qa)),
    .via     (via),
    .sum     (alu_sum),
    .replace (alu_replace)
  );

  `APSP_ASSERT_NEXT(a_read_path, in_accept && (operation == apsp_pkg::OP_READ), state == apsp_pkg::ST_READ, "read item did not go to read state")
  `APSP_ASSERT_NEXT(a_read_result, state == apsp_pkg::ST_READ, out_valid, "read gave no item")
  `APSP_ASSERT_IMPL(a_relax_bounds, state == apsp_pkg::ST_WR, (k_idx <= n_last) && (i_idx <= n_last) && (j_idx <= n_last), "relax index past node count")
  `APSP_ASSERT_IMPL(a_no_stray_write, (state == apsp_pkg::ST_RD1) || (state == apsp_pkg::ST_RD2) || (state == apsp_pkg::ST_READ), !ram_we, "matrix written during a read step")

endmodule
